>>> src/rci_pkg.sv
// shared types for the ray / circle intersection pipeline
`timescale 1ns / 1ps

package rci_pkg;

	// control that travels beside each item down the pipeline
	typedef struct packed {
		logic vld;   // stage holds an item
		logic neg;   // discriminant below zero, item is a miss
	} rci_ctl_t;

endpackage

>>> src/ray_circle_intersection.sv
// top level: ray / circle intersection pipeline with square root cell chain
`timescale 1ns / 1ps

// Fully pipelined 2d ray / circle test. An item is taken on any cycle with start
// high; busy never rises, so one item per clock is sustained. The result of each
// item appears with done high after it has passed the front stages for offset,
// products, h rounding, h squared and discriminant, then the square root cell
// chain (COORD_WIDTH + 4 cells, one root bit per cell), then the root select and
// saturation register. done, hit and distance are valid for one cycle only and
// cannot be held off. A miss (negative discriminant or both roots behind the
// origin) gives hit low and distance zero; distance saturates at all ones.
module ray_circle_intersection import rci_pkg::*; #(
	parameter int COORD_WIDTH   = 24,
	parameter int DIR_FRAC_BITS = 14
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [COORD_WIDTH-1:0]   origin_x,
	input  logic signed [COORD_WIDTH-1:0]   origin_y,
	input  logic signed [DIR_FRAC_BITS+1:0] dir_x,
	input  logic signed [DIR_FRAC_BITS+1:0] dir_y,
	input  logic signed [COORD_WIDTH-1:0]   centre_x,
	input  logic signed [COORD_WIDTH-1:0]   centre_y,
	input  logic        [COORD_WIDTH-2:0]   radius,
	output logic                            done,
	output logic                            hit,
	output logic        [COORD_WIDTH+1:0]   distance
);

	localparam int HW    = COORD_WIDTH + 4;
	localparam int SQW   = HW;
	localparam int RADW  = 2 * SQW;
	localparam int FW    = HW + 2;
	localparam int DISTW = COORD_WIDTH + 2;
	localparam int LAT   = SQW + 6;

	rci_ctl_t              ctl_c  [0:SQW];
	logic [RADW-1:0]       rad_c  [0:SQW];
	logic [SQW+1:0]        rem_c  [0:SQW];
	logic [SQW-1:0]        root_c [0:SQW];
	logic signed [HW-1:0]  h_c    [0:SQW];

	logic signed [FW-1:0]  s_ext, h_ext, near_n, far_n, d_n;
	logic                  hit_n;
	logic [DISTW-1:0]      dist_n;

	logic                  done_q, hit_q;
	logic [DISTW-1:0]      distance_q;

	assign busy = 1'b0;

	// offset, dot product, rounding of h and discriminant
	rci_front #(
		.COORD_WIDTH   (COORD_WIDTH),
		.DIR_FRAC_BITS (DIR_FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.origin_x (origin_x),
		.origin_y (origin_y),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.centre_x (centre_x),
		.centre_y (centre_y),
		.radius   (radius),
		.ctl      (ctl_c[0]),
		.h        (h_c[0]),
		.rad      (rad_c[0])
	);

	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	// square root chain, msb of the root first
	for (genvar i = 0; i < SQW; i++) begin : g_cell
		rci_sqrt_cell #(
			.SQW (SQW),
			.HW  (HW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl_prev  (ctl_c[i]),
			.rad_prev  (rad_c[i]),
			.rem_prev  (rem_c[i]),
			.root_prev (root_c[i]),
			.h_prev    (h_c[i]),
			.ctl       (ctl_c[i+1]),
			.rad       (rad_c[i+1]),
			.rem       (rem_c[i+1]),
			.root      (root_c[i+1]),
			.h         (h_c[i+1])
		);
	end

	// pick the nearest root that is not behind the origin, then saturate
	always_comb begin
		s_ext  = $signed(FW'(root_c[SQW]));
		h_ext  = FW'(h_c[SQW]);
		near_n = -h_ext - s_ext;
		far_n  = s_ext - h_ext;
		d_n    = near_n[FW-1] ? far_n : near_n;
		hit_n  = ctl_c[SQW].vld && !ctl_c[SQW].neg && (!near_n[FW-1] || !far_n[FW-1]);
		if (!hit_n) begin
			dist_n = '0;
		end else if (|d_n[FW-2:DISTW]) begin
			dist_n = '1;
		end else begin
			dist_n = d_n[DISTW-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			done_q <= ctl_c[SQW].vld;
			hit_q  <= hit_n;
		end
	end

	always_ff @(posedge clk) begin
		distance_q <= dist_n;
	end

	assign done     = done_q;
	assign hit      = hit_q;
	assign distance = distance_q;

`ifndef SYNTHESIS
	// every accepted item comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("item did not complete after pipeline latency");

	// a miss carries zero distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (distance == '0))
		else $error("miss with nonzero distance");

	// hit only rises with the result strobe
	a_hit_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !hit)
		else $error("hit without done");
`endif

endmodule

>>> src/rci_front.sv
// front pipeline: offset, dot product, rounding of h and the discriminant
`timescale 1ns / 1ps

module rci_front import rci_pkg::*; #(
	parameter int COORD_WIDTH   = 24,
	parameter int DIR_FRAC_BITS = 14
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [COORD_WIDTH-1:0]         origin_x,
	input  logic signed [COORD_WIDTH-1:0]         origin_y,
	input  logic signed [DIR_FRAC_BITS+1:0]       dir_x,
	input  logic signed [DIR_FRAC_BITS+1:0]       dir_y,
	input  logic signed [COORD_WIDTH-1:0]         centre_x,
	input  logic signed [COORD_WIDTH-1:0]         centre_y,
	input  logic        [COORD_WIDTH-2:0]         radius,
	output rci_ctl_t                              ctl,
	output logic signed [COORD_WIDTH+3:0]         h,
	output logic        [2*(COORD_WIDTH+4)-1:0]   rad
);

	localparam int DW    = DIR_FRAC_BITS + 2;
	localparam int WW    = COORD_WIDTH + 1;
	localparam int RW    = COORD_WIDTH - 1;
	localparam int HFW   = DW + WW + 1;
	localparam int HW    = HFW - DIR_FRAC_BITS;
	localparam int DISCW = 2 * HW + 1;
	localparam int RADW  = 2 * HW;
	localparam logic [HFW-1:0] RND = {{(HFW-1){1'b0}}, 1'b1} << (DIR_FRAC_BITS - 1);

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [WW-1:0]    wx_s1, wy_s1;
	logic signed [DW-1:0]    dx_s1, dy_s1;
	logic        [RW-1:0]    r_s1;
	logic signed [DW+WW-1:0] hx_s2, hy_s2;
	logic signed [2*WW-1:0]  wxx_s2, wyy_s2;
	logic        [2*RW-1:0]  rr_s2;
	logic signed [HW-1:0]    h_s3, h_s4, h_s5;
	logic signed [DISCW-1:0] q_s3, q_s4;
	logic signed [2*HW-1:0]  hh_s4;
	logic        [RADW-1:0]  rad_s5;
	logic                    neg_s5;

	logic        [HFW-1:0]   hf_r;
	logic signed [DISCW-1:0] q_n, disc_n;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// rounded dot product, the radius-minus-offset term and the discriminant sum
	always_comb begin
		hf_r   = HFW'(hx_s2) + HFW'(hy_s2) + RND;
		q_n    = DISCW'($signed({1'b0, rr_s2})) - DISCW'(wxx_s2) - DISCW'(wyy_s2);
		disc_n = DISCW'(hh_s4) + q_s4;
	end

	// payload stages
	always_ff @(posedge clk) begin
		// offset from centre
		wx_s1  <= WW'(origin_x) - WW'(centre_x);
		wy_s1  <= WW'(origin_y) - WW'(centre_y);
		dx_s1  <= dir_x;
		dy_s1  <= dir_y;
		r_s1   <= radius;
		// products
		hx_s2  <= dx_s1 * wx_s1;
		hy_s2  <= dy_s1 * wy_s1;
		wxx_s2 <= wx_s1 * wx_s1;
		wyy_s2 <= wy_s1 * wy_s1;
		rr_s2  <= r_s1 * r_s1;
		// h as a signed integer, floor after adding half
		h_s3   <= $signed(hf_r[HFW-1:DIR_FRAC_BITS]);
		q_s3   <= q_n;
		// h squared
		hh_s4  <= h_s3 * h_s3;
		h_s4   <= h_s3;
		q_s4   <= q_s3;
		// discriminant
		rad_s5 <= disc_n[RADW-1:0];
		neg_s5 <= disc_n[DISCW-1];
		h_s5   <= h_s4;
	end

	assign ctl.vld = vld_s5;
	assign ctl.neg = neg_s5;
	assign h       = h_s5;
	assign rad     = rad_s5;

endmodule

>>> src/rci_sqrt_cell.sv
// one cell of the square root chain: one root bit per cell
`timescale 1ns / 1ps

module rci_sqrt_cell import rci_pkg::*; #(
	parameter int SQW = 28,
	parameter int HW  = 28
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rci_ctl_t              ctl_prev,
	input  logic [2*SQW-1:0]      rad_prev,
	input  logic [SQW+1:0]        rem_prev,
	input  logic [SQW-1:0]        root_prev,
	input  logic signed [HW-1:0]  h_prev,
	output rci_ctl_t              ctl,
	output logic [2*SQW-1:0]      rad,
	output logic [SQW+1:0]        rem,
	output logic [SQW-1:0]        root,
	output logic signed [HW-1:0]  h
);

	localparam int RADW = 2 * SQW;
	localparam int RMW  = SQW + 2;

	rci_ctl_t              ctl_q;
	logic [RADW-1:0]       rad_q;
	logic [RMW-1:0]        rem_q;
	logic [SQW-1:0]        root_q;
	logic signed [HW-1:0]  h_q;

	logic [RMW-1:0] rem_sh, trial;
	logic           take;

	// bring down two radicand bits and try the next root bit
	always_comb begin
		rem_sh = {rem_prev[RMW-3:0], rad_prev[RADW-1:RADW-2]};
		trial  = {root_prev, 2'b01};
		take   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_prev;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= {rad_prev[RADW-3:0], 2'b00};
		rem_q  <= take ? (rem_sh - trial) : rem_sh;
		root_q <= {root_prev[SQW-2:0], take};
		h_q    <= h_prev;
	end

	assign ctl  = ctl_q;
	assign rad  = rad_q;
	assign rem  = rem_q;
	assign root = root_q;
	assign h    = h_q;

endmodule
